// ===== sv/atw_pkg.sv =====
// atw_pkg: shared types and constants for the ansi text terminal writer
// depends on nothing; imported by the parser, cursor and top-level modules

package atw_pkg;

	// field widths
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned ATTR_W   = 8;
	localparam int unsigned ADDR_W   = 16;
	localparam int unsigned WIDTH_W  = 8;

	// reset values
	localparam logic [ATTR_W-1:0]  ATTR_DEFAULT     = 8'h07;
	localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = 8'd80;

	// per-item event from the parser to the cursor logic
	typedef struct packed {
		logic write;
		logic newline;
	} text_ev_t;

endpackage

// ===== sv/atw_if.sv =====
// atw_if: valid/ready channel interfaces for character input and cell-write results
// depends on atw_pkg for field widths

interface atw_char_if
	import atw_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink (input valid, input char_byte, output ready);
endinterface

interface atw_result_if
	import atw_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic              write_enable;
	logic [ADDR_W-1:0] write_address;
	logic [CHAR_W-1:0] write_char;
	logic [ATTR_W-1:0] write_attribute;
	logic [ADDR_W-1:0] cursor_position;

	modport source (output valid, output write_enable, output write_address,
		output write_char, output write_attribute, output cursor_position,
		input ready);
	modport sink (input valid, input write_enable, input write_address,
		input write_char, input write_attribute, input cursor_position,
		output ready);
endinterface

// ===== sv/ansi_text_terminal_writer.sv =====
// ansi_text_terminal_writer: top level, parser and cursor logic feeding a result register
// depends on atw_pkg, atw_if, atw_parser and atw_cursor
//
//   channel     dir   handshake      payload
//   char_in     in    valid/ready    char_byte
//   result_out  out   valid/ready    write_enable, write_address, write_char,
//                                    write_attribute, cursor_position
//   cfg         in    cfg_we         cfg_wdata (line_width)
//
// one item per cycle while results are taken; each result appears in the cycle after its item is accepted
// the result register is the only stage, so a new item is taken whenever it is
// empty or being drained in the same cycle
// a stalled result holds char_in.ready low until it is taken
// arst_n clears parser, cursor, line width (80) and result valid; no clearing pass

module ansi_text_terminal_writer
	import atw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	atw_char_if.sink           char_in,
	atw_result_if.source       result_out,
	input  logic               cfg_we,
	input  logic [WIDTH_W-1:0] cfg_wdata
);

	logic              step;
	text_ev_t          ev;
	logic [ATTR_W-1:0] attribute;
	logic [ADDR_W-1:0] cursor;
	logic [ADDR_W-1:0] cursor_next;

	logic              valid_q;
	logic              we_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CHAR_W-1:0] char_q;
	logic [ATTR_W-1:0] attr_q;
	logic [ADDR_W-1:0] pos_q;

	// accept whenever the result register is free or draining
	assign char_in.ready = !valid_q || result_out.ready;
	assign step          = char_in.valid && char_in.ready;

	atw_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.char_byte (char_in.char_byte),
		.ev        (ev),
		.attribute (attribute)
	);

	atw_cursor u_cursor (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.ev          (ev),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cursor      (cursor),
		.cursor_next (cursor_next)
	);

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (char_in.ready)
			valid_q <= char_in.valid;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (step) begin
			we_q   <= ev.write;
			addr_q <= cursor;
			char_q <= ev.write ? char_in.char_byte : '0;
			attr_q <= ev.write ? attribute : '0;
			pos_q  <= cursor_next;
		end
	end

	assign result_out.valid           = valid_q;
	assign result_out.write_enable    = we_q;
	assign result_out.write_address   = addr_q;
	assign result_out.write_char      = char_q;
	assign result_out.write_attribute = attr_q;
	assign result_out.cursor_position = pos_q;

endmodule

// ===== sv/atw_parser.sv =====
// atw_parser: escape / CSI parser that keeps the current and pending attribute
// depends on atw_pkg; classifies each item as a cell write, a newline or neither

module atw_parser
	import atw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [CHAR_W-1:0] char_byte,
	output text_ev_t          ev,
	output logic [ATTR_W-1:0] attribute
);

	typedef enum logic [1:0] {
		MODE_TEXT = 2'd0,
		MODE_ESC  = 2'd1,
		MODE_CSI  = 2'd2
	} mode_t;

	localparam logic [CHAR_W-1:0] CHR_ESC  = 8'h1B;
	localparam logic [CHAR_W-1:0] CHR_LF   = 8'h0A;
	localparam logic [CHAR_W-1:0] CHR_LBRK = 8'h5B;
	localparam logic [CHAR_W-1:0] CHR_SEMI = 8'h3B;
	localparam logic [CHAR_W-1:0] CHR_M    = 8'h6D;
	localparam logic [CHAR_W-1:0] CHR_ZERO = 8'h30;

	localparam logic [ATTR_W-1:0] MASK_BRIGHT = 8'h08;
	localparam logic [ATTR_W-1:0] MASK_DIM    = 8'h77;
	localparam logic [ATTR_W-1:0] MASK_FG     = 8'hF8;
	localparam logic [ATTR_W-1:0] MASK_BG     = 8'h8F;

	mode_t             mode_q, mode_d;
	logic [3:0]        tens_q, tens_d;
	logic [3:0]        units_q, units_d;
	logic [1:0]        count_q, count_d;
	logic [ATTR_W-1:0] attr_q, attr_d;
	logic [ATTR_W-1:0] pend_q, pend_d;
	logic [ATTR_W-1:0] applied;
	logic [3:0]        digit;

	// apply the collected sgr parameter to the pending attribute
	function automatic logic [ATTR_W-1:0] apply_sgr(
		input logic [ATTR_W-1:0] a,
		input logic [3:0]        tens,
		input logic [3:0]        units,
		input logic [1:0]        cnt
	);
		logic [3:0]        hi;
		logic [3:0]        lo;
		logic [ATTR_W-1:0] r;
		hi = (cnt >= 2'd2) ? tens : 4'd0;
		lo = (cnt >= 2'd1) ? units : 4'd0;
		r  = a;
		case (hi)
			4'd0: begin
				if (lo == 4'd0)
					r = ATTR_DEFAULT;
				else if (lo == 4'd1)
					r = a | MASK_BRIGHT;
				else if (lo == 4'd2)
					r = a & MASK_DIM;
			end
			4'd3: r = (a & MASK_FG) | {4'd0, lo};
			4'd4: r = (a & MASK_BG) | {lo, 4'd0};
			default: r = a;
		endcase
		return r;
	endfunction

	assign applied   = apply_sgr(pend_q, tens_q, units_q, count_q);
	assign digit     = 4'(char_byte - CHR_ZERO);
	assign attribute = attr_q;

	// next state and event decode for one item
	always_comb begin
		mode_d     = mode_q;
		tens_d     = tens_q;
		units_d    = units_q;
		count_d    = count_q;
		attr_d     = attr_q;
		pend_d     = pend_q;
		ev.write   = 1'b0;
		ev.newline = 1'b0;
		case (mode_q)
			MODE_ESC: begin
				if (char_byte == CHR_LBRK) begin
					mode_d  = MODE_CSI;
					pend_d  = attr_q;
					tens_d  = 4'd0;
					units_d = 4'd0;
					count_d = 2'd0;
				end else begin
					mode_d = MODE_TEXT;
				end
			end
			MODE_CSI: begin
				case (char_byte) inside
					[8'h40:8'h7E]: begin
						// final byte: only 'm' commits
						if (char_byte == CHR_M) begin
							pend_d = applied;
							attr_d = applied;
						end
						tens_d  = 4'd0;
						units_d = 4'd0;
						count_d = 2'd0;
						mode_d  = MODE_TEXT;
					end
					[8'h30:8'h39]: begin
						if (count_q == 2'd0) begin
							units_d = digit;
							count_d = 2'd1;
						end else if (count_q == 2'd1) begin
							tens_d  = units_q;
							units_d = digit;
							count_d = 2'd2;
						end
					end
					CHR_SEMI: begin
						pend_d  = applied;
						tens_d  = 4'd0;
						units_d = 4'd0;
						count_d = 2'd0;
					end
					default: ;
				endcase
			end
			default: begin
				mode_d = MODE_TEXT;
				if (char_byte == CHR_ESC)
					mode_d = MODE_ESC;
				else if (char_byte == CHR_LF)
					ev.newline = 1'b1;
				else
					ev.write = 1'b1;
			end
		endcase
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_TEXT;
			tens_q  <= 4'd0;
			units_q <= 4'd0;
			count_q <= 2'd0;
			attr_q  <= ATTR_DEFAULT;
			pend_q  <= ATTR_DEFAULT;
		end else if (step) begin
			mode_q  <= mode_d;
			tens_q  <= tens_d;
			units_q <= units_d;
			count_q <= count_d;
			attr_q  <= attr_d;
			pend_q  <= pend_d;
		end
	end

endmodule

// ===== sv/atw_cursor.sv =====
// atw_cursor: cursor and column tracking plus the line width register
// depends on atw_pkg; driven by the parser's per-item event

module atw_cursor
	import atw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  text_ev_t           ev,
	input  logic               cfg_we,
	input  logic [WIDTH_W-1:0] cfg_wdata,
	output logic [ADDR_W-1:0]  cursor,
	output logic [ADDR_W-1:0]  cursor_next
);

	logic [WIDTH_W-1:0] line_width_q;
	logic [ADDR_W-1:0]  cursor_q;
	logic [WIDTH_W-1:0] column_q, column_d;
	logic [WIDTH_W:0]   column_inc;

	assign column_inc = {1'b0, column_q} + {{WIDTH_W{1'b0}}, 1'b1};
	assign cursor     = cursor_q;

	// advance on a write, line start of next line on a newline
	always_comb begin
		cursor_next = cursor_q;
		column_d    = column_q;
		if (ev.write) begin
			cursor_next = cursor_q + {{(ADDR_W-1){1'b0}}, 1'b1};
			if (column_inc >= {1'b0, line_width_q})
				column_d = '0;
			else
				column_d = column_inc[WIDTH_W-1:0];
		end else if (ev.newline) begin
			cursor_next = cursor_q - {{(ADDR_W-WIDTH_W){1'b0}}, column_q}
				+ {{(ADDR_W-WIDTH_W){1'b0}}, line_width_q};
			column_d    = '0;
		end
	end

	// line width register, to be written only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			line_width_q <= LINE_WIDTH_RESET;
		else if (cfg_we)
			line_width_q <= cfg_wdata;
	end

	// cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			column_q <= '0;
		end else if (step) begin
			cursor_q <= cursor_next;
			column_q <= column_d;
		end
	end

endmodule

// ===== tb/sv/atw_tb_pkg.sv =====
`timescale 1ns / 100ps
// atw_tb_pkg: character codes, sgr codes and the cell-write record for the writer testbench
// depends on atw_pkg for field widths; used by the checker and the testbench top

package atw_tb_pkg;
	import atw_pkg::*;

	// stream characters with a control meaning
	localparam logic [CHAR_W-1:0] CHR_LF         = 8'h0A;
	localparam logic [CHAR_W-1:0] CHR_ESC        = 8'h1B;
	localparam logic [CHAR_W-1:0] CHR_SPACE      = 8'h20;
	localparam logic [CHAR_W-1:0] CHR_DIGIT0     = 8'h30;
	localparam logic [CHAR_W-1:0] CHR_DIGIT9     = 8'h39;
	localparam logic [CHAR_W-1:0] CHR_PARAM_SEP  = 8'h3B;
	localparam logic [CHAR_W-1:0] CHR_FINAL_LO   = 8'h40;
	localparam logic [CHAR_W-1:0] CHR_CLEAR_FIN  = 8'h4A;
	localparam logic [CHAR_W-1:0] CHR_LBRACKET   = 8'h5B;
	localparam logic [CHAR_W-1:0] CHR_SGR_END    = 8'h6D;
	localparam logic [CHAR_W-1:0] CHR_FINAL_HI   = 8'h7E;

	// sgr parameter groups (tens digit) and basic codes (units digit)
	localparam logic [3:0] SGR_GROUP_BASIC = 4'd0;
	localparam logic [3:0] SGR_GROUP_FG    = 4'd3;
	localparam logic [3:0] SGR_GROUP_BG    = 4'd4;
	localparam logic [3:0] SGR_RESET       = 4'd0;
	localparam logic [3:0] SGR_BRIGHT      = 4'd1;
	localparam logic [3:0] SGR_DIM         = 4'd2;

	// attribute masks
	localparam logic [ATTR_W-1:0] BRIGHT_SET = 8'h08;
	localparam logic [ATTR_W-1:0] DIM_KEEP   = 8'h77;
	localparam logic [ATTR_W-1:0] FG_KEEP    = 8'hF8;
	localparam logic [ATTR_W-1:0] BG_KEEP    = 8'h8F;

	// legal line width range
	localparam int LINE_WIDTH_MIN = 1;
	localparam int LINE_WIDTH_MAX = 255;

	// one cell-write result
	typedef struct packed {
		logic              write_enable;
		logic [ADDR_W-1:0] write_address;
		logic [CHAR_W-1:0] write_char;
		logic [ATTR_W-1:0] write_attribute;
		logic [ADDR_W-1:0] cursor_position;
	} cell_write_t;

endpackage

// ===== tb/sv/atw_write_checker.sv =====
`timescale 1ns / 100ps
// atw_write_checker: watches the character and result channels, models the terminal writer
// and compares every cell-write result; depends on atw_pkg, atw_tb_pkg and the channel interfaces

module atw_write_checker
	import atw_pkg::*;
	import atw_tb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	atw_char_if                char_ch,
	atw_result_if              result_ch,
	input  logic               cfg_we,
	input  logic [WIDTH_W-1:0] cfg_wdata,
	output int                 fails,
	output int                 pending,
	output int                 checked,
	output int                 wraps
);

	typedef enum logic [1:0] {PM_TEXT, PM_ESC, PM_CSI} parse_mode_t;

	// terminal state
	logic [WIDTH_W-1:0] line_width;
	parse_mode_t        mode;
	logic [3:0]         tens;
	logic [3:0]         units;
	logic [1:0]         ndigits;
	logic [ATTR_W-1:0]  attr;
	logic [ATTR_W-1:0]  pend_attr;
	logic [ADDR_W-1:0]  cursor;
	logic [WIDTH_W-1:0] column;

	cell_write_t expected_cells[$];
	cell_write_t exp_cell;

	// one line per mismatch
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
		fails++;
	endtask

	task automatic clear_digits();
		tens = '0;
		units = '0;
		ndigits = '0;
	endtask

	// apply the collected parameter to the pending attribute
	task automatic apply_sgr();
		logic [3:0] hi;
		logic [3:0] lo;
		hi = (ndigits >= 2) ? tens : 4'd0;
		lo = (ndigits >= 1) ? units : 4'd0;
		case (hi)
			SGR_GROUP_BASIC: begin
				if (lo == SGR_RESET)
					pend_attr = ATTR_DEFAULT;
				else if (lo == SGR_BRIGHT)
					pend_attr = pend_attr | BRIGHT_SET;
				else if (lo == SGR_DIM)
					pend_attr = pend_attr & DIM_KEEP;
			end
			SGR_GROUP_FG: pend_attr = (pend_attr & FG_KEEP) | {4'd0, lo};
			SGR_GROUP_BG: pend_attr = (pend_attr & BG_KEEP) | {lo, 4'd0};
			default: ;
		endcase
		clear_digits();
	endtask

	// advance the terminal by one character and build its result
	task automatic step_terminal(input logic [CHAR_W-1:0] c, output cell_write_t res);
		logic [CHAR_W-1:0] digit;
		int                nxt;
		res = '0;
		res.write_address = cursor;
		case (mode)
			PM_ESC: begin
				if (c == CHR_LBRACKET) begin
					mode = PM_CSI;
					pend_attr = attr;
					clear_digits();
				end else begin
					mode = PM_TEXT;
				end
			end
			PM_CSI: begin
				if (c >= CHR_FINAL_LO && c <= CHR_FINAL_HI) begin
					// only 'm' commits, every other final byte drops the pending attribute
					if (c == CHR_SGR_END) begin
						apply_sgr();
						attr = pend_attr;
					end
					clear_digits();
					mode = PM_TEXT;
				end else if (c >= CHR_DIGIT0 && c <= CHR_DIGIT9) begin
					digit = c - CHR_DIGIT0;
					if (ndigits == 0) begin
						units = digit[3:0];
						ndigits = 1;
					end else if (ndigits == 1) begin
						tens = units;
						units = digit[3:0];
						ndigits = 2;
					end
				end else if (c == CHR_PARAM_SEP) begin
					apply_sgr();
				end
			end
			default: begin
				mode = PM_TEXT;
				if (c == CHR_ESC) begin
					mode = PM_ESC;
				end else if (c == CHR_LF) begin
					nxt = int'(cursor) - int'(column) + int'(line_width);
					if (nxt < 0 || nxt > 65535)
						wraps++;
					cursor = ADDR_W'(nxt);
					column = '0;
				end else begin
					res.write_enable = 1'b1;
					res.write_char = c;
					res.write_attribute = attr;
					if (cursor == '1)
						wraps++;
					cursor = cursor + ADDR_W'(1);
					if (int'(column) + 1 >= int'(line_width))
						column = '0;
					else
						column = column + WIDTH_W'(1);
				end
			end
		endcase
		res.cursor_position = cursor;
	endtask

	// compare one result with the oldest expectation
	task automatic check_result();
		cell_write_t want;
		if (expected_cells.size() == 0) begin
			report_mismatch("result with nothing expected, cursor", result_ch.cursor_position, 0);
			return;
		end
		want = expected_cells.pop_front();
		checked++;
		if (result_ch.write_enable !== want.write_enable)
			report_mismatch("write_enable", result_ch.write_enable, want.write_enable);
		if (result_ch.write_address !== want.write_address)
			report_mismatch("write_address", result_ch.write_address, want.write_address);
		if (result_ch.write_char !== want.write_char)
			report_mismatch("write_char", result_ch.write_char, want.write_char);
		if (result_ch.write_attribute !== want.write_attribute)
			report_mismatch("write_attribute", result_ch.write_attribute,
				want.write_attribute);
		if (result_ch.cursor_position !== want.cursor_position)
			report_mismatch("cursor_position", result_ch.cursor_position,
				want.cursor_position);
	endtask

	// track config, results and items at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width = LINE_WIDTH_RESET;
			mode = PM_TEXT;
			clear_digits();
			attr = ATTR_DEFAULT;
			pend_attr = ATTR_DEFAULT;
			cursor = '0;
			column = '0;
			expected_cells.delete();
			fails = 0;
			checked = 0;
			wraps = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				line_width = cfg_wdata;
			if (result_ch.valid && result_ch.ready)
				check_result();
			if (char_ch.valid && char_ch.ready) begin
				step_terminal(char_ch.char_byte, exp_cell);
				expected_cells.push_back(exp_cell);
			end
			pending = expected_cells.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// testbench: drives characters and line width into the terminal writer under several idle patterns
// depends on atw_pkg, atw_tb_pkg, the channel interfaces, atw_write_checker and the rtl top

module testbench;
	import atw_pkg::*;
	import atw_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [WIDTH_W-1:0] cfg_wdata;

	int idle_pct;
	int stall_pct;
	int sent;
	int quiet_cycles;
	int fails;
	int pending;
	int checked;
	int wraps;

	atw_char_if   char_ch();
	atw_result_if result_ch();

	ansi_text_terminal_writer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (char_ch),
		.result_out (result_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	atw_write_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_ch   (char_ch),
		.result_ch (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fails     (fails),
		.pending   (pending),
		.checked   (checked),
		.wraps     (wraps)
	);

	always #5 clk = ~clk;

	// result side back-pressure
	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (char_ch.valid && char_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one character, called and returning at a falling edge
	task automatic send_byte(input logic [CHAR_W-1:0] b);
		while ($urandom_range(99) < idle_pct) begin
			char_ch.valid <= 1'b0;
			@(negedge clk);
		end
		char_ch.valid <= 1'b1;
		char_ch.char_byte <= b;
		@(posedge clk);
		while (!char_ch.ready)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// stop sending and wait until every result is back
	task automatic hold_off();
		char_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	task automatic set_line_width(input logic [WIDTH_W-1:0] w);
		hold_off();
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// text, nul, 0xff, newline, swallowed escape, long csi, empty parameter, discarding final
	task automatic run_directed();
		logic [CHAR_W-1:0] script[$];
		script = '{8'h41, 8'h00, 8'hFF, CHR_LF,
			CHR_ESC, 8'h78,
			CHR_ESC, CHR_LBRACKET, CHR_DIGIT0 + 8'd3, CHR_DIGIT0 + 8'd1, CHR_DIGIT0 + 8'd5,
			CHR_ESC, CHR_LF, CHR_PARAM_SEP, CHR_DIGIT0 + 8'd4, CHR_DIGIT0 + 8'd6,
			CHR_PARAM_SEP, CHR_DIGIT0 + 8'd1, CHR_SGR_END,
			8'h43,
			CHR_ESC, CHR_LBRACKET, CHR_PARAM_SEP, CHR_CLEAR_FIN,
			8'h44};
		foreach (script[i])
			send_byte(script[i]);
	endtask

	// well-formed csi with random parameters and mostly an 'm' final
	task automatic send_sgr_sequence();
		int nparams;
		int value;
		int form;
		send_byte(CHR_ESC);
		send_byte(CHR_LBRACKET);
		nparams = $urandom_range(3, 1);
		for (int i = 0; i < nparams; i++) begin
			if (i > 0)
				send_byte(CHR_PARAM_SEP);
			case ($urandom_range(5))
				0: value = SGR_RESET;
				1: value = SGR_BRIGHT;
				2: value = SGR_DIM;
				3: value = 10 * SGR_GROUP_FG + $urandom_range(9);
				4: value = 10 * SGR_GROUP_BG + $urandom_range(9);
				default: value = $urandom_range(99);
			endcase
			// empty, leading zero, plain or with a surplus third digit
			form = $urandom_range(9);
			if (form != 0) begin
				if (form == 1 && value < 10)
					send_byte(CHR_DIGIT0);
				if (value >= 10)
					send_byte(CHR_DIGIT0 + 8'(value / 10));
				send_byte(CHR_DIGIT0 + 8'(value % 10));
				if (form == 2)
					send_byte(CHR_DIGIT0 + 8'($urandom_range(9)));
			end
		end
		if ($urandom_range(4) != 0)
			send_byte(CHR_SGR_END);
		else
			send_byte(8'($urandom_range(CHR_FINAL_HI, CHR_FINAL_LO)));
	endtask

	task automatic send_random_chunk();
		int pick;
		int n;
		pick = $urandom_range(99);
		if (pick < 40) begin
			n = $urandom_range(6, 1);
			repeat (n)
				send_byte(8'($urandom_range(255)));
		end else if (pick < 52) begin
			send_byte(CHR_LF);
		end else if (pick < 85) begin
			send_sgr_sequence();
		end else if (pick < 92) begin
			send_byte(CHR_ESC);
			send_byte(8'($urandom_range(255)));
		end else begin
			// broken csi: random bytes, possibly no final byte
			send_byte(CHR_ESC);
			send_byte(CHR_LBRACKET);
			n = $urandom_range(4, 1);
			repeat (n)
				send_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic run_random_phase(input int count, input int idle, input int stall);
		int target;
		int mid;
		bit paused;
		idle_pct = idle;
		stall_pct = stall;
		target = sent + count;
		mid = sent + count / 2;
		paused = 0;
		while (sent < target) begin
			// one full drain in the middle of every phase
			if (!paused && sent >= mid) begin
				hold_off();
				paused = 1;
			end
			send_random_chunk();
		end
	endtask

	// nearly all newlines at the widest line so the cursor runs past 0xffff
	task automatic run_wrap_phase(input int count);
		idle_pct = 0;
		stall_pct = 0;
		repeat (count) begin
			if ($urandom_range(49) == 0)
				send_byte(8'($urandom_range(CHR_FINAL_HI, CHR_SPACE)));
			else
				send_byte(CHR_LF);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		char_ch.valid = 1'b0;
		char_ch.char_byte = '0;
		result_ch.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		sent = 0;
		quiet_cycles = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		set_line_width(8'(LINE_WIDTH_MAX));
		run_wrap_phase(280);
		set_line_width(8'(LINE_WIDTH_MIN));
		run_random_phase(30, 0, 0);
		set_line_width(8'(LINE_WIDTH_MAX));
		run_random_phase(30, 84, 0);
		set_line_width(8'($urandom_range(LINE_WIDTH_MAX - 1, LINE_WIDTH_MIN + 1)));
		run_random_phase(30, 0, 84);
		set_line_width(8'($urandom_range(LINE_WIDTH_MAX, LINE_WIDTH_MIN)));
		run_random_phase(30, 37, 37);

		hold_off();
		repeat (4) @(negedge clk);
		$display("run covered %0d characters and %0d checked cell results", sent, checked);
		$display("line widths from 1 to 255 under four idle patterns, cursor wrapped %0d times",
			wraps);
		if (fails == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
